// ----- sv/mavr_pkg.sv -----
package mavr_pkg;

  localparam int MAX_WINDOW = 256;
  localparam int ADDR_W     = $clog2(MAX_WINDOW);
  localparam int LEN_W      = ADDR_W + 1;
  localparam int CFG_W      = 8;
  localparam int SAMPLE_W   = 32;
  localparam int AVG_W      = 32;
  localparam int SUM_W      = 64;
  localparam int TOTAL_W    = SAMPLE_W + ADDR_W;
  localparam int CARRY_W    = LEN_W + 1;
  localparam int DIV_STEPS  = TOTAL_W;
  localparam int CNT_W      = $clog2(DIV_STEPS);
  localparam int S_TDATA_W  = SAMPLE_W;
  localparam int M_TDATA_W  = AVG_W + SUM_W;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_TOTAL,
    ST_DIV,
    ST_FIX
  } mavr_state_t;

  typedef struct packed {
    logic take_in;
    logic rd_mem;
    logic upd_total;
    logic div_step;
    logic finish;
  } mavr_cmd_t;

  typedef struct packed {
    logic n_is_one;
  } mavr_status_t;

endpackage

// ----- sv/mavr_ctrl.sv -----
module mavr_ctrl (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  output logic                  m_tvalid,
  input  logic                  m_tready,
  input  mavr_pkg::mavr_status_t status,
  output mavr_pkg::mavr_cmd_t    cmd
);

  mavr_pkg::mavr_state_t state, state_next;
  logic [mavr_pkg::CNT_W-1:0] cnt;
  logic out_free;

  assign out_free = !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= mavr_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (state == mavr_pkg::ST_TOTAL) begin
      cnt <= '0;
    end else if (state == mavr_pkg::ST_DIV) begin
      cnt <= cnt + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd.finish) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      mavr_pkg::ST_IDLE: begin
        if (s_tvalid) begin
          state_next = status.n_is_one ? mavr_pkg::ST_FIX : mavr_pkg::ST_READ;
        end
      end
      mavr_pkg::ST_READ:  state_next = mavr_pkg::ST_TOTAL;
      mavr_pkg::ST_TOTAL: state_next = mavr_pkg::ST_DIV;
      mavr_pkg::ST_DIV: begin
        if (cnt == mavr_pkg::CNT_W'(mavr_pkg::DIV_STEPS - 1)) begin
          state_next = mavr_pkg::ST_FIX;
        end
      end
      mavr_pkg::ST_FIX: begin
        if (out_free) begin
          state_next = mavr_pkg::ST_IDLE;
        end
      end
      default: state_next = mavr_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    s_tready = 1'b0;
    unique case (state)
      mavr_pkg::ST_IDLE: begin
        s_tready    = 1'b1;
        cmd.take_in = s_tvalid;
      end
      mavr_pkg::ST_READ:  cmd.rd_mem    = 1'b1;
      mavr_pkg::ST_TOTAL: cmd.upd_total = 1'b1;
      mavr_pkg::ST_DIV:   cmd.div_step  = 1'b1;
      mavr_pkg::ST_FIX:   cmd.finish    = out_free;
      default: begin
      end
    endcase
  end

`ifndef SYNTH
  a_long_window_reads: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready && !status.n_is_one) |=> state == mavr_pkg::ST_READ)
    else $error("accepted item did not start a store read");

  a_finish_shows: assert property (@(posedge clk) disable iff (rst)
    cmd.finish |=> m_tvalid)
    else $error("finished item not presented");

  a_div_count: assert property (@(posedge clk) disable iff (rst)
    (state == mavr_pkg::ST_DIV) |-> cnt <= mavr_pkg::CNT_W'(mavr_pkg::DIV_STEPS - 1))
    else $error("divider step count overran");
`endif

endmodule

// ----- sv/mavr_dp.sv -----
module mavr_dp (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_wen,
  input  logic [mavr_pkg::CFG_W-1:0]        cfg_wdata,
  input  logic [mavr_pkg::S_TDATA_W-1:0]    s_tdata,
  input  mavr_pkg::mavr_cmd_t               cmd,
  output mavr_pkg::mavr_status_t            status,
  output logic [mavr_pkg::M_TDATA_W-1:0]    m_tdata
);

  logic [mavr_pkg::CFG_W-1:0]    window_extra;
  logic [mavr_pkg::LEN_W-1:0]    n;
  logic [mavr_pkg::SAMPLE_W-1:0] x;
  logic [mavr_pkg::ADDR_W-1:0]   widx;
  logic [mavr_pkg::MAX_WINDOW-1:0] valid;
  logic [mavr_pkg::SAMPLE_W-1:0] store [mavr_pkg::MAX_WINDOW];
  logic [mavr_pkg::SAMPLE_W-1:0] rd_data;
  logic                          rd_valid;
  logic [mavr_pkg::TOTAL_W-1:0]  total, total_next;
  logic                          neg;
  logic [mavr_pkg::TOTAL_W-1:0]  dvd;
  logic [mavr_pkg::TOTAL_W-1:0]  quo;
  logic [mavr_pkg::LEN_W-1:0]    rem;
  logic [mavr_pkg::LEN_W:0]      rem_sh;
  logic [mavr_pkg::LEN_W:0]      n_wide;
  logic                          ge;
  logic [mavr_pkg::CARRY_W-1:0]  carry, carry_sum, carry_fix, r_s, n_s;
  logic [mavr_pkg::TOTAL_W-1:0]  q_s;
  logic [mavr_pkg::AVG_W-1:0]    avg_fix, avg_out;
  logic [mavr_pkg::AVG_W-1:0]    last_avg;
  logic [mavr_pkg::SUM_W-1:0]    emitted_sum, sum_next, add_val;
  logic                          clear;

  assign n               = mavr_pkg::LEN_W'(window_extra) + 1'b1;
  assign status.n_is_one = (window_extra == '0);
  assign clear           = rst || cfg_wen;

  always_ff @(posedge clk) begin
    if (rst) begin
      window_extra <= '0;
    end else if (cfg_wen) begin
      window_extra <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.take_in) begin
      x <= s_tdata;
    end
  end

  // sample store: one write and one registered read per cycle
  always_ff @(posedge clk) begin
    if (cmd.upd_total) begin
      store[widx] <= x;
    end
    if (cmd.rd_mem) begin
      rd_data  <= store[widx];
      rd_valid <= valid[widx];
    end
  end

  assign total_next = total + mavr_pkg::TOTAL_W'($signed(x))
                    - (rd_valid ? mavr_pkg::TOTAL_W'($signed(rd_data)) : '0);

  always_ff @(posedge clk) begin
    if (clear) begin
      valid <= '0;
      widx  <= '0;
      total <= '0;
    end else if (cmd.upd_total) begin
      valid[widx] <= 1'b1;
      total       <= total_next;
      widx        <= (mavr_pkg::CFG_W'(widx) == window_extra) ? '0 : widx + 1'b1;
    end
  end

  // restoring divider on the magnitude, one quotient bit per step
  assign n_wide = {1'b0, n};
  assign rem_sh = {rem, dvd[mavr_pkg::TOTAL_W-1]};
  assign ge     = (rem_sh >= n_wide);

  always_ff @(posedge clk) begin
    if (cmd.upd_total) begin
      neg <= total_next[mavr_pkg::TOTAL_W-1];
      dvd <= total_next[mavr_pkg::TOTAL_W-1] ? -total_next : total_next;
      quo <= '0;
      rem <= '0;
    end else if (cmd.div_step) begin
      dvd <= {dvd[mavr_pkg::TOTAL_W-2:0], 1'b0};
      quo <= {quo[mavr_pkg::TOTAL_W-2:0], ge};
      rem <= ge ? mavr_pkg::LEN_W'(rem_sh - n_wide) : rem_sh[mavr_pkg::LEN_W-1:0];
    end
  end

  // sign the quotient and remainder, then fold the remainder into the carry
  always_comb begin
    q_s       = neg ? -quo : quo;
    r_s       = neg ? -mavr_pkg::CARRY_W'(rem) : mavr_pkg::CARRY_W'(rem);
    n_s       = mavr_pkg::CARRY_W'(n);
    carry_sum = carry + r_s;
    carry_fix = carry_sum;
    avg_fix   = q_s[mavr_pkg::AVG_W-1:0];
    if ($signed(carry_sum) >= $signed(n_s)) begin
      carry_fix = carry_sum - n_s;
      avg_fix   = q_s[mavr_pkg::AVG_W-1:0] + 1'b1;
    end else if ($signed(carry_sum) <= -$signed(n_s)) begin
      carry_fix = carry_sum + n_s;
      avg_fix   = q_s[mavr_pkg::AVG_W-1:0] - 1'b1;
    end
    add_val  = status.n_is_one ? mavr_pkg::SUM_W'($signed(x))
                               : mavr_pkg::SUM_W'($signed(last_avg));
    sum_next = emitted_sum + add_val;
    avg_out  = status.n_is_one ? x : avg_fix;
  end

  always_ff @(posedge clk) begin
    if (clear) begin
      carry       <= '0;
      last_avg    <= '0;
      emitted_sum <= '0;
    end else if (cmd.finish) begin
      emitted_sum <= sum_next;
      if (!status.n_is_one) begin
        carry    <= carry_fix;
        last_avg <= avg_fix;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      m_tdata <= {sum_next, avg_out};
    end
  end

`ifndef SYNTH
  a_carry_range: assert property (@(posedge clk) disable iff (rst)
    ($signed(carry) < $signed(mavr_pkg::CARRY_W'(n)))
      && ($signed(carry) > -$signed(mavr_pkg::CARRY_W'(n))))
    else $error("remainder carry left the window range");

  a_index_in_window: assert property (@(posedge clk) disable iff (rst)
    cmd.upd_total |-> mavr_pkg::CFG_W'(widx) <= window_extra)
    else $error("store index beyond window");
`endif

endmodule

// ----- sv/moving_average_remainder_filter.sv -----
// Moving-average filter with remainder carry.
//
// Input stream (s_tvalid/s_tready/s_tdata): one signed 32-bit sample per item.
// Output stream (m_tvalid/m_tready/m_tdata): one result per item, holding the
// carry-corrected window average and the running sum of emitted averages.
// Configuration: cfg_wen/cfg_wdata write the window register (N = value + 1);
// a write clears the sample store, the window total, the carry, the last average
// and the running sum. Write it only while no item is in flight.
//
// With N = 1 an accepted item goes straight to the correction step, which loads
// the output register. With N > 1 the item passes through one store read, one
// total update, 40 steps of the bit-serial divider (40-bit total by the 9-bit
// window length), and one correction step. The divider sets the rate; the block
// takes a new item only when it is through with the last, so one item is in
// flight at a time.
//
// Reset (rst, synchronous) sets N = 1 and clears the control and accumulator
// state; store entries are tracked by valid bits, so no clearing pass is needed.
// A stalled receiver holds the result in the output register; the block still
// accepts and works on the next item, then waits until the register frees.
module moving_average_remainder_filter (
  input  logic                           clk,
  input  logic                           rst,
  // config: window length minus one
  input  logic                           cfg_wen,
  input  logic [mavr_pkg::CFG_W-1:0]     cfg_wdata,
  // input item
  input  logic                           s_tvalid,
  output logic                           s_tready,
  input  logic [mavr_pkg::S_TDATA_W-1:0] s_tdata,   // [31:0] sample
  // result item
  output logic                           m_tvalid,
  input  logic                           m_tready,
  output logic [mavr_pkg::M_TDATA_W-1:0] m_tdata    // [31:0] average, [95:32] running_sum
);

  mavr_pkg::mavr_cmd_t    cmd;
  mavr_pkg::mavr_status_t status;

  // sequence the read, total, divide and correction steps
  mavr_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .status   (status),
    .cmd      (cmd)
  );

  // store, window total, divider, carry and output register
  mavr_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_wen   (cfg_wen),
    .cfg_wdata (cfg_wdata),
    .s_tdata   (s_tdata),
    .cmd       (cmd),
    .status    (status),
    .m_tdata   (m_tdata)
  );

endmodule
